@@ rtl/core/ip_prefix_access_filter_core_macros.svh @@
// Assertion helpers used by the access filter controller.
`ifndef IP_PREFIX_ACCESS_FILTER_CORE_MACROS_SVH
`define IP_PREFIX_ACCESS_FILTER_CORE_MACROS_SVH

// Checked property on the rising clock edge, suspended while reset is high.
`define IPAF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked property on the rising clock edge, also evaluated during reset.
`define IPAF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ rtl/core/ipaf_pkg.sv @@
package ipaf_pkg;

   // Request mode codes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   // Verdict reason codes.
   localparam logic [2:0] REASON_BLOCK_RULE = 3'd0;
   localparam logic [2:0] REASON_ALLOW_RULE = 3'd1;
   localparam logic [2:0] REASON_PRIVATE    = 3'd2;
   localparam logic [2:0] REASON_PUBLIC     = 3'd3;
   localparam logic [2:0] REASON_UNLISTED   = 3'd4;

   // Kind of decision the controller hands to the datapath.
   localparam logic [1:0] KIND_BLOCK    = 2'd0;
   localparam logic [1:0] KIND_ALLOW    = 2'd1;
   localparam logic [1:0] KIND_DEFAULT  = 2'd2;
   localparam logic [1:0] KIND_UNLISTED = 2'd3;

   // Prefix handling.
   localparam logic [7:0]   V4_PREFIX_MAX = 8'd32;
   localparam logic [7:0]   V6_PREFIX_MAX = 8'd128;
   localparam logic [31:0]  V4_ONES       = 32'hFFFF_FFFF;
   localparam logic [127:0] V6_ONES       = {128{1'b1}};

   // Private address ranges.
   localparam logic [7:0] OCT_TEN      = 8'd10;
   localparam logic [7:0] OCT_172      = 8'd172;
   localparam logic [3:0] OCT_172_HIGH = 4'h1;  // second octet 16..31
   localparam logic [7:0] OCT_192      = 8'd192;
   localparam logic [7:0] OCT_168      = 8'd168;
   localparam logic [7:0] OCT_LOOP     = 8'd127;
   localparam logic [7:0] ULA_MASK     = 8'hFE;
   localparam logic [7:0] ULA_VALUE    = 8'hFC;

   typedef struct packed {
      logic        mode;
      logic        list_select;
      logic [3:0]  rule_slot;
      logic        rule_enable;
      logic        family_v6;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [7:0]  prefix_bits;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [2:0] verdict_reason;
      logic [3:0] matched_slot;
   } rsp_type;

   // One stored rule.
   typedef struct packed {
      logic        is_v6;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [7:0]  prefix;
   } rule_type;

   typedef struct packed {
      logic       load_wr;
      logic       latch_client;
      logic       rd_en;
      logic       capture;
      logic [1:0] kind;
      logic [3:0] slot;
      logic       out_push;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic any_allow;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/ipaf_ram.sv @@
module ipaf_ram #(
   parameter int WIDTH = 137,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ipaf_ctrl.sv @@
`include "ip_prefix_access_filter_core_macros.svh"

module ipaf_ctrl #(
   parameter int RULES_PER_LIST = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_mode,
   output logic                                req_ready,
   input  ipaf_pkg::status_type                st,
   output ipaf_pkg::cmd_type                   cmd,
   output logic [$clog2(2*RULES_PER_LIST)-1:0] rd_addr,
   output logic [$clog2(2*RULES_PER_LIST)-1:0] chk_idx
);

   import ipaf_pkg::*;

   localparam int TOTAL = 2 * RULES_PER_LIST;
   localparam int AW    = $clog2(TOTAL);
   localparam int IW    = AW + 1;

   localparam logic [AW-1:0] FIRST_ALLOW = AW'(RULES_PER_LIST);
   localparam logic [AW-1:0] LAST_BLOCK  = AW'(RULES_PER_LIST - 1);
   localparam logic [AW-1:0] LAST_ALL    = AW'(TOTAL - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] iss_ff, iss_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic          in_block;
   logic [AW-1:0] slot_rel;
   logic [AW+3:0] slot_ext;

   assign in_block = chk_idx_ff < FIRST_ALLOW;
   assign slot_rel = in_block ? chk_idx_ff : chk_idx_ff - FIRST_ALLOW;
   assign slot_ext = {4'b0, slot_rel};

   always_comb begin
      state_in   = state_ff;
      iss_in     = iss_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.slot   = slot_ext[3:0];
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_CHECK) begin
                  cmd.latch_client = 1'b1;
                  iss_in           = '0;
                  state_in         = S_SCAN;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (iss_ff < IW'(TOTAL)) begin
               cmd.rd_en  = 1'b1;
               iss_in     = iss_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[AW-1:0];
            end
            if (chk_vld_ff) begin
               if (st.hit) begin
                  cmd.capture = 1'b1;
                  cmd.kind    = in_block ? KIND_BLOCK : KIND_ALLOW;
               end else if (chk_idx_ff == LAST_BLOCK && !st.any_allow) begin
                  cmd.capture = 1'b1;
                  cmd.kind    = KIND_DEFAULT;
               end else if (chk_idx_ff == LAST_ALL) begin
                  cmd.capture = 1'b1;
                  cmd.kind    = KIND_UNLISTED;
               end
               if (cmd.capture) begin
                  chk_vld_in = 1'b0;
                  state_in   = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (st.out_free) begin
               cmd.out_push = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         iss_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         iss_ff     <= iss_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
   end

   assign rd_addr = iss_ff[AW-1:0];
   assign chk_idx = chk_idx_ff;

   `IPAF_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == S_IDLE, "controller not idle after reset")
   `IPAF_ASSERT(a_capture_needs_read, cmd.capture |-> chk_vld_ff, "decision without rule read")
   `IPAF_ASSERT(a_capture_then_wait, cmd.capture |=> state_ff == S_WAIT, "decision not held")
   `IPAF_ASSERT(a_push_when_free, cmd.out_push |-> st.out_free, "result pushed over full output")

endmodule

@@ rtl/core/ipaf_dpath.sv @@
module ipaf_dpath #(
   parameter int RULES_PER_LIST = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ipaf_pkg::cmd_type                   cmd,
   input  ipaf_pkg::req_type                   req_data,
   input  logic [$clog2(2*RULES_PER_LIST)-1:0] rd_addr,
   input  logic [$clog2(2*RULES_PER_LIST)-1:0] chk_idx,
   output ipaf_pkg::status_type                st,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ipaf_pkg::rsp_type                   rsp_data
);

   import ipaf_pkg::*;

   localparam int TOTAL = 2 * RULES_PER_LIST;
   localparam int AW    = $clog2(TOTAL);
   localparam int CW    = $clog2(RULES_PER_LIST + 1);

   // Request fields with the IPv4 form normalized: upper word zero, low 32 bits only.
   logic [63:0]   in_upper, in_lower;
   logic          slot_ok;
   logic [AW+3:0] wr_addr_full;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   rule_type      wr_rule;

   logic [TOTAL-1:0] valid_ff, valid_in;
   logic [CW-1:0]    allow_cnt_ff, allow_cnt_in;

   logic        cl_v6_ff;
   logic [63:0] cl_upper_ff, cl_lower_ff;

   rule_type       rd_rule;
   logic [7:0]     p6;
   logic [7:0]     p4;
   logic [127:0]   mask6;
   logic [31:0]    mask4;
   logic [127:0]   diff6;
   logic           match;
   logic           priv;
   logic [7:0]     oct0, oct1;

   rsp_type pend_ff, pend_in;
   rsp_type out_ff;
   logic    out_vld_ff, out_vld_in;

   assign in_upper = req_data.family_v6 ? req_data.addr_upper : 64'd0;
   assign in_lower = req_data.family_v6 ? req_data.addr_lower
                                        : {32'd0, req_data.addr_lower[31:0]};

   // Loads aimed beyond the list are dropped.
   assign slot_ok      = {{(AW + 4 - 4){1'b0}}, req_data.rule_slot}
                         < (AW + 4)'(RULES_PER_LIST);
   assign wr_addr_full = (req_data.list_select ? (AW + 4)'(RULES_PER_LIST) : '0)
                         + {{AW{1'b0}}, req_data.rule_slot};
   assign wr_addr      = wr_addr_full[AW-1:0];
   assign wr_en        = cmd.load_wr && slot_ok;

   assign wr_rule.is_v6      = req_data.family_v6;
   assign wr_rule.addr_upper = in_upper;
   assign wr_rule.addr_lower = in_lower;
   assign wr_rule.prefix     = req_data.prefix_bits;

   always_comb begin
      valid_in     = valid_ff;
      allow_cnt_in = allow_cnt_ff;
      if (wr_en) begin
         valid_in[wr_addr] = req_data.rule_enable;
         if (req_data.list_select) begin
            if (req_data.rule_enable && !valid_ff[wr_addr]) begin
               allow_cnt_in = allow_cnt_ff + 1'b1;
            end else if (!req_data.rule_enable && valid_ff[wr_addr]) begin
               allow_cnt_in = allow_cnt_ff - 1'b1;
            end
         end
      end
   end

   ipaf_ram #(
      .WIDTH($bits(rule_type)),
      .DEPTH(TOTAL)
   ) u_rules (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_rule),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_rule)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch_client) begin
         cl_v6_ff    <= req_data.family_v6;
         cl_upper_ff <= in_upper;
         cl_lower_ff <= in_lower;
      end
   end

   // Prefix match of the rule just read against the client.
   assign p6    = (rd_rule.prefix > V6_PREFIX_MAX) ? V6_PREFIX_MAX : rd_rule.prefix;
   assign p4    = (rd_rule.prefix > V4_PREFIX_MAX) ? V4_PREFIX_MAX : rd_rule.prefix;
   assign mask6 = ~(V6_ONES >> p6);
   assign mask4 = ~(V4_ONES >> p4);
   assign diff6 = {cl_upper_ff ^ rd_rule.addr_upper, cl_lower_ff ^ rd_rule.addr_lower};

   always_comb begin
      if (rd_rule.is_v6 != cl_v6_ff) begin
         match = 1'b0;
      end else if (cl_v6_ff) begin
         match = (diff6 & mask6) == 128'd0;
      end else begin
         match = (diff6[31:0] & mask4) == 32'd0;
      end
   end

   assign oct0 = cl_lower_ff[31:24];
   assign oct1 = cl_lower_ff[23:16];

   always_comb begin
      if (cl_v6_ff) begin
         priv = ((cl_upper_ff[63:56] & ULA_MASK) == ULA_VALUE)
                || (cl_upper_ff == 64'd0 && cl_lower_ff == 64'd1);
      end else begin
         priv = (oct0 == OCT_TEN)
                || (oct0 == OCT_172 && oct1[7:4] == OCT_172_HIGH)
                || (oct0 == OCT_192 && oct1 == OCT_168)
                || (oct0 == OCT_LOOP);
      end
   end

   assign st.hit       = valid_ff[chk_idx] && match;
   assign st.any_allow = allow_cnt_ff != '0;
   assign st.out_free  = !out_vld_ff || rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (cmd.capture) begin
         case (cmd.kind)
            KIND_BLOCK: begin
               pend_in = '{allowed: 1'b0, verdict_reason: REASON_BLOCK_RULE,
                           matched_slot: cmd.slot};
            end
            KIND_ALLOW: begin
               pend_in = '{allowed: 1'b1, verdict_reason: REASON_ALLOW_RULE,
                           matched_slot: cmd.slot};
            end
            KIND_DEFAULT: begin
               pend_in = '{allowed: priv,
                           verdict_reason: priv ? REASON_PRIVATE : REASON_PUBLIC,
                           matched_slot: 4'd0};
            end
            default: begin
               pend_in = '{allowed: 1'b0, verdict_reason: REASON_UNLISTED,
                           matched_slot: 4'd0};
            end
         endcase
      end
   end

   assign out_vld_in = cmd.out_push || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         allow_cnt_ff <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         allow_cnt_ff <= allow_cnt_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (cmd.out_push) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

@@ rtl/core/ip_prefix_access_filter_core.sv @@
// A load request gives no response and leaves the block idle and ready for the next request.
// A check scans the block list, then the allow list, one rule per cycle through the rule
// RAM read port, and stops at the first hit. The next request is accepted only after the
// verdict has moved into the response register, which holds a previous response until
// the consumer takes it.
// Synchronous active-high reset clears all rule valid bits and the response valid flag.
module ip_prefix_access_filter_core #(
   parameter int RULES_PER_LIST = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ipaf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ipaf_pkg::rsp_type rsp_data
);

   import ipaf_pkg::*;

   localparam int AW = $clog2(2 * RULES_PER_LIST);

   // The controller sequences the scan; the datapath owns the rule store, the
   // per-entry valid bits, the client address, the matcher and the response register.
   cmd_type       cmd;
   status_type    st;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] chk_idx;

   // Rule entries are arranged with the block list at indices 0 to RULES_PER_LIST-1
   // and the allow list above it. The RAM read is registered, so the controller keeps
   // one index in flight: while rule k is compared, rule k+1 is being read. A hit, or
   // the end of a list, freezes the decision into a pending register, which moves
   // to the response register once the consumer has room.
   ipaf_ctrl #(
      .RULES_PER_LIST(RULES_PER_LIST)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_mode (req_data.mode),
      .req_ready(req_ready),
      .st       (st),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .chk_idx  (chk_idx)
   );

   // When no allow rule is valid, the check ends after the block list and the
   // verdict falls back to the private address ranges of the client's family.
   ipaf_dpath #(
      .RULES_PER_LIST(RULES_PER_LIST)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rd_addr  (rd_addr),
      .chk_idx  (chk_idx),
      .st       (st),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
